[rtl/swm_pkg.sv]
`default_nettype none

package swm_pkg;

  // default sizes handed to the top level
  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // window size register
  localparam int              CFG_W        = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

  // controller to datapath commands
  typedef struct packed {
    logic accept;  // take the input transaction: ring write and sorted insert
    logic read;    // fetch the oldest sample from the ring
    logic remove;  // load the median result and delete the oldest sample
  } swm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;      // the sample being accepted fills the window
    logic out_free;  // the output register can take a result this cycle
  } swm_stat_t;

endpackage

`default_nettype wire

[rtl/swm_ctrl.sv]
`default_nettype none

module swm_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  swm_pkg::swm_stat_t stat,
  output swm_pkg::swm_cmd_t  cmd
);
  import swm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_READ   = 3'b010,
    S_REMOVE = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // command decode
  always_comb begin
    in_ready   = (state_r == S_IDLE);
    cmd.accept = (state_r == S_IDLE) && in_valid;
    cmd.read   = (state_r == S_READ);
    cmd.remove = (state_r == S_REMOVE) && stat.out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && stat.full) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_REMOVE;
      end
      S_REMOVE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/swm_datapath.sv]
`default_nettype none

module swm_datapath #(
  parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire        [swm_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire signed [SAMPLE_BITS-1:0]     in_sample,
  input  wire                              in_restart,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [SAMPLE_BITS:0]      out_median_doubled,
  input  swm_pkg::swm_cmd_t                cmd,
  output swm_pkg::swm_stat_t               stat
);
  import swm_pkg::*;

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]              win_cfg_r;
  logic [CNT_W-1:0]              fc_r, fc_nxt;
  logic [CNT_W-1:0]              rp_r, rp_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS:0]   out_median_r;
  logic signed [SAMPLE_BITS-1:0] old_r;

  logic signed [SAMPLE_BITS-1:0] ring_r   [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cell_r   [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cell_nxt [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cell_up  [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cell_dn  [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]         le, le_prev, ge;

  logic [CMP_W-1:0]   cfg_ext;
  logic [CNT_W-1:0]   win_act;
  logic               do_empty;
  logic [CNT_W-1:0]   fc_eff, rp_eff, fc_inc, rp_inc;
  logic [CNT_W:0]     slot_sum, slot;
  logic [IDX_W-1:0]   slot_idx;
  logic [CNT_W-1:0]   mid_hi, mid_lo;
  logic signed [SAMPLE_BITS:0] median;

  // active window size: zero means one, saturate at the store depth
  always_comb begin
    cfg_ext = CMP_W'(win_cfg_r);
    if (cfg_ext == '0) begin
      win_act = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_WINDOW)) begin
      win_act = CNT_W'(MAX_WINDOW);
    end else begin
      win_act = cfg_ext[CNT_W-1:0];
    end
  end

  // window bookkeeping for the incoming transaction
  always_comb begin
    do_empty = in_restart || (fc_r >= win_act) || (rp_r >= win_act);
    fc_eff   = do_empty ? '0 : fc_r;
    rp_eff   = do_empty ? '0 : rp_r;
    fc_inc   = fc_eff + CNT_W'(1);
    slot_sum = {1'b0, rp_eff} + {1'b0, fc_eff};
    slot     = (slot_sum >= {1'b0, win_act}) ? slot_sum - {1'b0, win_act} : slot_sum;
    slot_idx = slot[IDX_W-1:0];
    rp_inc   = (rp_r + CNT_W'(1) == win_act) ? '0 : rp_r + CNT_W'(1);
  end

  // status to controller
  always_comb begin
    stat.full     = (fc_inc == win_act);
    stat.out_free = !out_valid_r || out_ready;
  end

  // median of the full window, doubled
  always_comb begin
    mid_hi = win_act >> 1;
    mid_lo = win_act[0] ? mid_hi : mid_hi - CNT_W'(1);
    median = {cell_r[mid_lo[IDX_W-1:0]][SAMPLE_BITS-1], cell_r[mid_lo[IDX_W-1:0]]}
           + {cell_r[mid_hi[IDX_W-1:0]][SAMPLE_BITS-1], cell_r[mid_hi[IDX_W-1:0]]};
  end

  // per-cell compares and neighbor taps of the sorted array
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      le[i] = (CNT_W'(i) < fc_eff) && (cell_r[i] <= in_sample);
      ge[i] = (CNT_W'(i) < fc_r) && (cell_r[i] >= old_r);
    end
    le_prev[0] = 1'b1;
    cell_dn[0] = cell_r[0];
    for (int i = 1; i < MAX_WINDOW; i++) begin
      le_prev[i] = le[i-1];
      cell_dn[i] = cell_r[i-1];
    end
    for (int i = 0; i < MAX_WINDOW - 1; i++) begin
      cell_up[i] = cell_r[i+1];
    end
    cell_up[MAX_WINDOW-1] = cell_r[MAX_WINDOW-1];
  end

  // sorted array update: insert after equal values, or delete one copy
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      cell_nxt[i] = cell_r[i];
      if (cmd.accept) begin
        if (le[i]) begin
          cell_nxt[i] = cell_r[i];
        end else if (le_prev[i]) begin
          cell_nxt[i] = in_sample;
        end else begin
          cell_nxt[i] = cell_dn[i];
        end
      end else if (cmd.remove) begin
        if (ge[i]) begin
          cell_nxt[i] = cell_up[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  // arrival ring: write on accept, registered read of the oldest slot
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring_r[slot_idx] <= in_sample;
    end
    if (cmd.read) begin
      old_r <= ring_r[rp_r[IDX_W-1:0]];
    end
  end

  // fill count and ring pointer
  always_comb begin
    fc_nxt = fc_r;
    rp_nxt = rp_r;
    if (cfg_we) begin
      fc_nxt = '0;
      rp_nxt = '0;
    end else if (cmd.accept) begin
      fc_nxt = fc_inc;
      rp_nxt = rp_eff;
    end else if (cmd.remove) begin
      fc_nxt = fc_r - CNT_W'(1);
      rp_nxt = rp_inc;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.remove) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.remove) begin
      out_median_r <= median;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r   <= WINDOW_RESET;
      fc_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_cfg_r <= cfg_wdata;
      end
      fc_r        <= fc_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = out_median_r;

endmodule

`default_nettype wire

[rtl/sliding_window_median_core.sv]
// latency: a transaction that fills the window gives its result in out_valid after the S_READ
//   and S_REMOVE states (ring read after the insert, then result load with delete of the oldest)
// throughput: one sample per cycle while the window fills, then each sample waits for the ring read
//   and the delete pass over the sorted cell array, which stalls while the output register is full
// reset: synchronous active-low rst_n empties the window and sets the window size to 3;
//   sample stores are not cleared and no clearing pass runs
`default_nettype none

module sliding_window_median_core #(
  parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire        [swm_pkg::CFG_W-1:0] cfg_wdata,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire signed [SAMPLE_BITS-1:0]    in_sample,
  input  wire                             in_restart,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic signed [SAMPLE_BITS:0]     out_median_doubled
);
  import swm_pkg::*;

  swm_cmd_t  cmd;
  swm_stat_t stat;

  // sequencing
  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // window stores, sorted cell array and result register
  swm_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_sample          (in_sample),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_median_doubled (out_median_doubled),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule

`default_nettype wire

[tb/sliding_window_median_core_tb.sv]
`default_nettype none

module sliding_window_median_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIN     = swm_pkg::MAX_WINDOW_DEF;
  localparam int SBITS       = swm_pkg::SAMPLE_BITS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 8;

  // idling modes, one per phase
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // median predictor and store of expected medians
  class median_scoreboard;
    logic signed [SBITS-1:0] arrival[MAX_WIN];
    logic signed [SBITS-1:0] ordered[MAX_WIN];
    int                      oldest;
    int                      held;
    logic [swm_pkg::CFG_W-1:0] win_reg;
    logic signed [SBITS:0]   medians_q[$];
    int                      mismatches;
    int                      checked;

    function new();
      win_reg    = swm_pkg::WINDOW_RESET;
      oldest     = 0;
      held       = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function int active_window();
      if (win_reg == 0) return 1;
      if (win_reg > MAX_WIN) return MAX_WIN;
      return int'(win_reg);
    endfunction

    // register write also empties the window
    function void set_window(logic [swm_pkg::CFG_W-1:0] value);
      win_reg = value;
      oldest  = 0;
      held    = 0;
    endfunction

    // accepted input transaction: update window, maybe queue a median
    function void note_input(logic signed [SBITS-1:0] smp, logic restart);
      int w;
      int pos;
      int i;
      logic signed [SBITS-1:0] gone;
      logic signed [SBITS:0]   med;
      w = active_window();
      if (restart) begin
        oldest = 0;
        held   = 0;
      end
      if (held >= w || oldest >= w) begin
        oldest = 0;
        held   = 0;
      end
      arrival[(oldest + held) % w] = smp;
      // sorted insert, after equal values
      pos = 0;
      while (pos < held && ordered[pos] <= smp) pos++;
      for (i = held; i > pos; i--) ordered[i] = ordered[i-1];
      ordered[pos] = smp;
      held++;
      if (held < w) return;
      if (w % 2 == 1) begin
        med = {ordered[w/2], 1'b0};
      end else begin
        med = {ordered[w/2-1][SBITS-1], ordered[w/2-1]} +
              {ordered[w/2][SBITS-1], ordered[w/2]};
      end
      medians_q.insert(medians_q.size(), med);
      // drop the oldest sample from the sorted store
      gone = arrival[oldest];
      pos  = 0;
      while (pos < held && ordered[pos] != gone) pos++;
      if (pos < held) begin
        for (i = pos; i < held - 1; i++) ordered[i] = ordered[i+1];
      end
      oldest = (oldest + 1) % w;
      held--;
    endfunction

    // accepted result transaction against the oldest expectation
    function void check_result(logic signed [SBITS:0] actual);
      logic signed [SBITS:0] want;
      checked++;
      if (medians_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: median_doubled %0d", actual);
        return;
      end
      want = medians_q.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: median_doubled expected %0d actual %0d", want, actual);
      end
    endfunction

    function int pending();
      return medians_q.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [swm_pkg::CFG_W-1:0]  cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  wire                        in_ready;
  logic signed [SBITS-1:0]    in_sample = '0;
  logic                       in_restart = 1'b0;
  wire                        out_valid;
  logic                       out_ready = 1'b0;
  wire signed [SBITS:0]       out_median_doubled;

  median_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;
  int samples_sent  = 0;
  int restarts_sent = 0;
  int windows_used  = 0;

  sliding_window_median_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_median_doubled (out_median_doubled)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // result side: check, stall at random, count quiet cycles
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_median_doubled);
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    out_ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // watchdog
  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("sliding_window_median_core test failed");
    $finish;
  end

  function automatic void set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 69;
        stall_pct     = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct     = 69;
      end
      default: begin
        send_idle_pct = 8;
        stall_pct     = 8;
      end
    endcase
  endfunction

  // one input transaction, with optional idle cycles ahead of it
  task automatic send_sample(input logic signed [SBITS-1:0] smp, input logic restart);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_sample  <= smp;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    sb.note_input(smp, restart);
    samples_sent++;
    if (restart) restarts_sent++;
  endtask

  // hold the sender until every expected median has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_window(input logic [swm_pkg::CFG_W-1:0] value);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_window(value);
    windows_used++;
  endtask

  // mostly full-range values, some near zero for duplicates, some extremes
  function automatic logic signed [SBITS-1:0] pick_sample();
    int sel;
    sel = $urandom_range(9, 0);
    if (sel == 0) return ($urandom_range(1, 0) != 0) ? 16'sh7FFF : 16'sh8000;
    if (sel <= 2) return SBITS'($signed($urandom_range(6, 0)) - 3);
    return SBITS'($urandom);
  endfunction

  // stimulus
  initial begin : main
    logic [swm_pkg::CFG_W-1:0] win_plan[12];
    logic [swm_pkg::CFG_W-1:0] win_val;
    int ph;
    int n;
    int count;
    int w;
    win_plan = '{7'd1, 7'd2, 7'd4, 7'd64, 7'd5, 7'd127,
                 7'd8, 7'd0, 7'd16, 7'd100, 7'd7, 7'd6};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset window of three
    set_idling(IDLE_NONE);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    // equal samples
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    // largest and smallest medians
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    // sequence shorter than the window, then a fresh one
    send_sample(16'sd1, 1'b1);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd7, 1'b1);
    send_sample(16'sd8, 1'b0);
    send_sample(16'sd9, 1'b0);

    // window size zero acts as one
    write_window(7'd0);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd3, 1'b1);

    // even window
    write_window(7'd2);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7FFE, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);

    // random phases over several window sizes and idling modes
    for (ph = 0; ph < 12; ph++) begin
      win_val = (ph == 10) ? 7'($urandom_range(12, 1)) : win_plan[ph];
      write_window(win_val);
      set_idling(idle_mode_t'(ph % 4));
      w     = sb.active_window();
      count = (w >= 32) ? 110 : 45;
      for (n = 0; n < count; n++) begin
        if ((ph == 2 || ph == 6) && n == count / 2) wait_drained();
        send_sample(pick_sample(), $urandom_range(3 * w + 8, 1) == 1);
      end
    end

    // drain and settle
    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d samples with %0d restarts over %0d window settings",
             samples_sent, restarts_sent, windows_used);
    $display("checked %0d medians, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("sliding_window_median_core test passed");
    end else begin
      $display("sliding_window_median_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/swm_pkg.sv
rtl/swm_ctrl.sv
rtl/swm_datapath.sv
rtl/sliding_window_median_core.sv
tb/sliding_window_median_core_tb.sv
